/* sv/aes_pkg.sv */
`default_nettype none
package aes_pkg;

  localparam int unsigned KeyWords = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RkDepth = 30;
  localparam int unsigned RkAddrW = 5;

  localparam logic [CfgIdxW-1:0] RegKey0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMode = 3'd4;

  localparam logic [7:0] SboxF [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SboxI [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SboxF[w[31:24]], SboxF[w[23:16]], SboxF[w[15:8]], SboxF[w[7:0]]};
  endfunction

  // one column, byte r at bits 8r+7:8r
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[7:0]; a1 = c[15:8]; a2 = c[23:16]; a3 = c[31:24];
    mix_col[7:0]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
    mix_col[15:8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
    mix_col[23:16] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
    mix_col[31:24] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [31:0] u;
    logic [7:0] p, q;
    // inverse = forward mix after a premultiply by {04}x^2+{05}
    p = xt(xt(c[7:0] ^ c[23:16]));
    q = xt(xt(c[15:8] ^ c[31:24]));
    u = c ^ {q, p, q, p};
    inv_mix_col = mix_col(u);
  endfunction

endpackage
`default_nettype wire

/* sv/aes_ram.sv */
`default_nettype none
module aes_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 30,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/aes_round.sv */
`default_nettype none
// one cipher round (the last one omits MixColumns) on the 128-bit state, byte i at bits 8i+7:8i
module aes_round (
  input  wire logic         dec_i,
  input  wire logic         last_i,
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] key_i,
  output logic      [127:0] state_o
);
  logic [127:0] sb, sr, mc, k;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[8*i +: 8] = dec_i ? aes_pkg::SboxI[state_i[8*i +: 8]] : aes_pkg::SboxF[state_i[8*i +: 8]];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sr[8*(r+4*c) +: 8] = dec_i ? sb[8*(r+4*((c+4-r)%4)) +: 8]
                                   : sb[8*(r+4*((c+r)%4)) +: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mc[32*c +: 32] = dec_i ? aes_pkg::inv_mix_col(sr[32*c +: 32])
                             : aes_pkg::mix_col(sr[32*c +: 32]);
      k[32*c +: 32]  = aes_pkg::inv_mix_col(key_i[32*c +: 32]);
    end
    if (last_i) state_o = sr ^ key_i;
    else if (dec_i) state_o = mc ^ k;
    else state_o = mc ^ key_i;
  end
endmodule
`default_nettype wire

/* sv/aes_ecb_block_cipher.sv */
`default_nettype none
// AES-128/256 block cipher, one 128-bit block per transaction, encrypt or decrypt.
// Write the key words and key_length_mode while idle; the first block after any key
// or mode write first expands the key into a 30 x 64-bit round key RAM, one 32-bit
// word per cycle (44 or 60 words). The round key RAM has one 64-bit read port, so
// each of the Nr+1 round keys is fetched as two halves (StRdLo, StRdHi) before
// StRound, in which the state takes either the initial key add or one round of the
// shared round unit. The result is held in an output register; the next block is
// accepted the cycle after the result has been taken.
module aes_ecb_block_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [63:0] block_hi_i,
  input  wire logic [63:0] block_lo_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [63:0] result_hi_o,
  output logic      [63:0] result_lo_o
);
  typedef enum logic [2:0] {
    StIdle, StExp, StRdLo, StRdHi, StRound, StDone
  } state_e;

  state_e state_q;
  logic [63:0] key_q [aes_pkg::KeyWords];
  logic mode_q, expanded_q, dec_q;
  logic [127:0] st_q;
  logic [63:0] klo_q;
  logic [5:0] wi_q;           // expansion word index
  logic [255:0] win_q;        // last nk words, word j at 32j
  logic [7:0] rcon_q;
  logic [31:0] wlo_q;
  logic [3:0] rnd_q, cnt_q;   // rnd_q: round key index, cnt_q: key adds done
  logic [3:0] nr;
  logic [5:0] total;

  logic ram_we;
  logic [aes_pkg::RkAddrW-1:0] ram_wa, ram_ra;
  logic [63:0] ram_rd;
  logic [31:0] new_w, t, cur_w;
  logic [127:0] rnd_out;
  logic [3:0] nk;

  assign nr = mode_q ? 4'd14 : 4'd10;
  assign nk = mode_q ? 4'd8 : 4'd4;
  assign total = mode_q ? 6'd60 : 6'd44;

  aes_ram #(.Width(64), .Depth(aes_pkg::RkDepth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i({cur_w, wlo_q}),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  aes_round u_round (
    .dec_i(dec_q), .last_i(cnt_q == nr), .state_i(st_q),
    .key_i({ram_rd, klo_q}), .state_o(rnd_out)
  );

  // key schedule step on the previous word
  always_comb begin
    logic [31:0] prev, old;
    logic [2:0] m;
    prev = mode_q ? win_q[255:224] : win_q[127:96];
    old  = win_q[31:0];
    m = mode_q ? wi_q[2:0] : {1'b0, wi_q[1:0]};
    if (m == 3'd0) t = aes_pkg::sub_word({prev[7:0], prev[31:8]}) ^ {24'd0, rcon_q};
    else if (mode_q && m == 3'd4) t = aes_pkg::sub_word(prev);
    else t = prev;
    new_w = old ^ t;
  end

  // key words go out unchanged, later words come from the schedule step
  assign cur_w = (wi_q < {2'b0, nk}) ? win_q[31:0] : new_w;

  assign ram_we = (state_q == StExp) && wi_q[0];
  assign ram_wa = wi_q[5:1];
  assign ram_ra = (state_q == StRdLo) ? {rnd_q, 1'b0} : {rnd_q, 1'b1};
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StDone);
  assign result_hi_o = st_q[127:64];
  assign result_lo_o = st_q[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q <= 1'b0;
      expanded_q <= 1'b0;
      for (int i = 0; i < aes_pkg::KeyWords; i++) key_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          aes_pkg::RegKey0: begin key_q[0] <= cfg_data_i; expanded_q <= 1'b0; end
          aes_pkg::RegKey1: begin key_q[1] <= cfg_data_i; expanded_q <= 1'b0; end
          aes_pkg::RegKey2: begin key_q[2] <= cfg_data_i; expanded_q <= 1'b0; end
          aes_pkg::RegKey3: begin key_q[3] <= cfg_data_i; expanded_q <= 1'b0; end
          aes_pkg::RegMode: begin mode_q <= cfg_data_i[0]; expanded_q <= 1'b0; end
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: if (in_valid_i) begin
          dec_q <= action_i;
          st_q <= {block_hi_i, block_lo_i};
          rnd_q <= action_i ? nr : 4'd0;
          cnt_q <= 4'd0;
          if (expanded_q) state_q <= StRdLo;
          else begin
            // the key words themselves are w[0..nk-1]
            win_q <= {mode_q ? {key_q[3], key_q[2]} : 128'd0, key_q[1], key_q[0]};
            wi_q <= 6'd0;
            rcon_q <= 8'h01;
            state_q <= StExp;
          end
        end
        StExp: begin
          // first nk words pass straight from the key window
          if (wi_q < {2'b0, nk}) begin
            wlo_q <= win_q[31:0];
            win_q <= mode_q ? {win_q[31:0], win_q[255:32]}
                            : {128'd0, win_q[31:0], win_q[127:32]};
          end else begin
            wlo_q <= new_w;
            win_q <= mode_q ? {new_w, win_q[255:32]} : {128'd0, new_w, win_q[127:32]};
            if ((mode_q ? wi_q[2:0] : {1'b0, wi_q[1:0]}) == 3'd0)
              rcon_q <= aes_pkg::xt(rcon_q);
          end
          wi_q <= wi_q + 6'd1;
          if (wi_q == total - 6'd1) begin
            expanded_q <= 1'b1;
            state_q <= StRdLo;
          end
        end
        StRdLo: state_q <= StRdHi;
        StRdHi: begin
          klo_q <= ram_rd;
          state_q <= StRound;
          rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
        end
        StRound: begin
          // the first key is a plain add before any round
          st_q <= (cnt_q == 4'd0) ? (st_q ^ {ram_rd, klo_q}) : rnd_out;
          cnt_q <= cnt_q + 4'd1;
          state_q <= (cnt_q == nr) ? StDone : StRdLo;
        end
        StDone: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
